/* sv/urrg_pkg.sv */
package urrg_pkg;

   // field widths fixed by the interface
   localparam int DATA_W      = 8;
   localparam int LEN_W       = 6;
   localparam int GAP_W       = 16;
   localparam int CMD_W       = 2;
   // pointer fields are sized for the largest supported ring (256 entries)
   localparam int PTR_MAX_W   = 8;
   // depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_RECV  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] rx_byte;
      logic [LEN_W-1:0]  read_len;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              has_data;
      logic              last;
      logic [LEN_W-1:0]  count;
   } rsp_type;

   // read job: start of the span to drain and its length, zero for an empty answer
   typedef struct packed {
      logic [PTR_MAX_W-1:0] start_ptr;
      logic [LEN_W-1:0]     len;
   } job_type;

   // ring write port
   typedef struct packed {
      logic                 we;
      logic [PTR_MAX_W-1:0] addr;
      logic [DATA_W-1:0]    data;
   } wr_type;

endpackage

/* sv/urrg_front.sv */
module urrg_front #(
   parameter int RING_SIZE = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  urrg_pkg::req_type   req,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   output logic                job_push,
   output urrg_pkg::job_type   job,
   output urrg_pkg::wr_type    wr
);
   import urrg_pkg::*;

   localparam int PTR_W = $clog2(RING_SIZE);
   localparam int CW    = (PTR_W + 1 > LEN_W) ? PTR_W + 1 : LEN_W;
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_SIZE - 1);
   localparam logic [PTR_W-1:0] HALF     = PTR_W'(RING_SIZE / 2);
   localparam logic [PTR_W:0]   RS_X     = (PTR_W + 1)'(RING_SIZE);

   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [GAP_W-1:0] gap_ff, gap_in;
   logic [GAP_W-1:0] interval_ff;

   logic [PTR_W-1:0] wp_next;
   logic             ring_full;
   logic [PTR_W:0]   fill_sum;
   logic [PTR_W-1:0] filled;
   logic [PTR_W-1:0] filled_after;
   logic [CW-1:0]    len_x;
   logic [CW-1:0]    fill_x;
   logic [LEN_W-1:0] take;
   logic [LEN_W-1:0] take_eff;
   logic [PTR_W:0]   rp_sum;
   logic [PTR_W:0]   rp_wrap;

   // ring occupancy and next write slot
   assign wp_next   = (wp_ff == LAST_IDX) ? '0 : wp_ff + 1'b1;
   assign ring_full = (wp_next == rp_ff);
   assign fill_sum  = {1'b0, wp_ff} + RS_X - {1'b0, rp_ff};
   assign filled    = (fill_sum >= RS_X) ? PTR_W'(fill_sum - RS_X) : fill_sum[PTR_W-1:0];
   assign filled_after = ring_full ? filled : filled + 1'b1;

   // read length: smaller of the request and the fill, nothing while the gap runs
   assign len_x    = CW'(req.read_len);
   assign fill_x   = CW'(filled);
   assign take     = (len_x < fill_x) ? req.read_len : LEN_W'(filled);
   assign take_eff = (gap_ff != '0) ? '0 : take;
   assign rp_sum   = {1'b0, rp_ff} + (PTR_W + 1)'(take_eff);
   assign rp_wrap  = (rp_sum >= RS_X) ? rp_sum - RS_X : rp_sum;

   // command decode and state update
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      gap_in = gap_ff;
      if (accept) begin
         unique case (req.cmd)
            CMD_RECV: begin
               if (!ring_full) wp_in = wp_next;
               gap_in = (filled_after > HALF) ? '0 : interval_ff;
            end
            CMD_TICK: begin
               if (gap_ff != '0) gap_in = gap_ff - 1'b1;
            end
            CMD_READ: begin
               rp_in = rp_wrap[PTR_W-1:0];
            end
            CMD_FLUSH: begin
               wp_in  = rp_ff;
               gap_in = '0;
            end
            default: begin
               wp_in = wp_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         gap_ff      <= '0;
         interval_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         gap_ff <= gap_in;
         if (csr_we) interval_ff <= csr_wdata;
      end
   end

   // read job toward the back
   assign job_push      = accept && (req.cmd == CMD_READ);
   assign job.start_ptr = PTR_MAX_W'(rp_ff);
   assign job.len       = take_eff;

   // ring write for a stored byte
   assign wr.we   = accept && (req.cmd == CMD_RECV) && !ring_full;
   assign wr.addr = PTR_MAX_W'(wp_ff);
   assign wr.data = req.rx_byte;

endmodule

/* sv/urrg_queue.sv */
module urrg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  urrg_pkg::job_type push_job,
   input  logic              pop,
   output logic              not_empty,
   output urrg_pkg::job_type head_job
);
   import urrg_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign not_empty = (cnt_ff != '0);
   assign head_job  = slot_ff[rd_idx_ff];
   assign do_push   = push && (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign do_pop    = pop && not_empty;

   // index and occupancy bookkeeping
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      cnt_in    = cnt_ff;
      if (do_push) wr_idx_in = (wr_idx_ff == LAST_SLOT) ? '0 : wr_idx_ff + 1'b1;
      if (do_pop)  rd_idx_in = (rd_idx_ff == LAST_SLOT) ? '0 : rd_idx_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         cnt_ff    <= cnt_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_idx_ff] <= push_job;
   end

endmodule

/* sv/urrg_back.sv */
module urrg_back #(
   parameter int RING_SIZE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  urrg_pkg::wr_type  wr,
   input  logic              job_valid,
   input  urrg_pkg::job_type job,
   output logic              job_pop,
   output logic              active,
   output logic              rsp_strobe,
   output urrg_pkg::rsp_type rsp
);
   import urrg_pkg::*;

   localparam int PTR_W = $clog2(RING_SIZE);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_SIZE - 1);

   logic [DATA_W-1:0] ring_mem [RING_SIZE];

   logic              active_ff, active_in;
   logic [PTR_W-1:0]  addr_ff, addr_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [LEN_W-1:0]  total_ff, total_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_has_ff, out_has_in;
   logic              out_last_ff, out_last_in;
   logic [LEN_W-1:0]  out_count_ff, out_count_in;
   logic [DATA_W-1:0] rdata_ff;

   assign job_pop = job_valid && !active_ff;
   assign active  = active_ff;

   // drain sequencer: one ring read per cycle, empty answers go straight out
   always_comb begin
      active_in    = active_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;
      total_in     = total_ff;
      out_valid_in = 1'b0;
      out_has_in   = 1'b0;
      out_last_in  = 1'b1;
      out_count_in = '0;
      if (active_ff) begin
         out_valid_in = 1'b1;
         out_has_in   = 1'b1;
         out_last_in  = (remain_ff == LEN_W'(1));
         out_count_in = total_ff;
         addr_in      = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
         remain_in    = remain_ff - 1'b1;
         if (remain_ff == LEN_W'(1)) active_in = 1'b0;
      end else if (job_pop) begin
         if (job.len == '0) begin
            out_valid_in = 1'b1;
         end else begin
            active_in = 1'b1;
            addr_in   = job.start_ptr[PTR_W-1:0];
            remain_in = job.len;
            total_in  = job.len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      remain_ff    <= remain_in;
      total_ff     <= total_in;
      out_has_ff   <= out_has_in;
      out_last_ff  <= out_last_in;
      out_count_ff <= out_count_in;
   end

   // ring storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr.we) ring_mem[wr.addr[PTR_W-1:0]] <= wr.data;
      if (active_ff) rdata_ff <= ring_mem[addr_ff];
   end

   // result register
   assign rsp_strobe    = out_valid_ff;
   assign rsp.data_byte = out_has_ff ? rdata_ff : '0;
   assign rsp.has_data  = out_has_ff;
   assign rsp.last      = out_last_ff;
   assign rsp.count     = out_count_ff;

endmodule

/* sv/uart_rx_ring_gap_gated_core.sv */
// channel   ports                        handshake
// request   start, busy, req             taken when start && !busy
// response  rsp_strobe, rsp              each result shown for one cycle, no back-pressure
// csr       csr_we, csr_wdata            gap interval written when csr_we
//
// receive, tick and flush do not queue a job; busy stays low for them
// a read holds busy while its job waits in the queue and while the back drains it,
// reading one ring entry per cycle from a single read port
// an empty answer passes the job queue and the result register; a drain's first byte
// passes the queue, the drain sequencer and the ring read register, then one per cycle
// reset is synchronous; pointers, gap count and gap interval clear, the ring does not
// the receiver cannot stall: every result is shown for exactly one cycle
module uart_rx_ring_gap_gated_core #(
   parameter int RING_SIZE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  urrg_pkg::req_type req,
   output logic              rsp_strobe,
   output urrg_pkg::rsp_type rsp,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   import urrg_pkg::*;

   logic    accept;
   logic    job_push;
   job_type job_front;
   job_type job_head;
   wr_type  wr;
   logic    job_valid;
   logic    job_pop;
   logic    back_active;

   // request acceptance; reads are taken only when no drain is pending
   assign accept = start && !busy;
   assign busy   = job_valid || back_active;

   // classify and apply commands
   urrg_front #(.RING_SIZE(RING_SIZE)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .job_push  (job_push),
      .job       (job_front),
      .wr        (wr)
   );

   // read jobs between front and back
   urrg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (job_front),
      .pop       (job_pop),
      .not_empty (job_valid),
      .head_job  (job_head)
   );

   // ring storage and drain
   urrg_back #(.RING_SIZE(RING_SIZE)) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .job_valid  (job_valid),
      .job        (job_head),
      .job_pop    (job_pop),
      .active     (back_active),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   // an answer without data is always the single empty answer
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.has_data |-> rsp.last && (rsp.count == '0) && (rsp.data_byte == '0))
      else $error("empty read answer malformed");

   // a taken read keeps the block busy in the next cycle
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req.cmd == CMD_READ) |=> busy)
      else $error("read request did not hold busy");

   // a drain delivers its results in consecutive cycles
   a_drain_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.last |=> rsp_strobe && $stable(rsp.count))
      else $error("read drain broke or changed count");

   // no request is taken while results of a drain are still to come
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.last |-> busy)
      else $error("request accepted during drain");

endmodule
